// ----- hdl/size_class_block_allocator_macros.svh -----
// Assertion macros for the size class block allocator checker.
// Depends on signals named clk and rst in the scope of each use.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define SCBA_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, evaluated also during reset.
`define SCBA_CHECK_AFTER(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/scba_pkg.sv -----
// Shared types and constants of the size class block allocator.
// Used by the front, back, top level and checker; depends on nothing.
`timescale 1ns / 1ps

package scba_pkg;

  localparam int BLK_W   = 7;
  localparam int SIZE_W  = 24;
  localparam int BYTES_W = 21;
  localparam int HDR_W   = 13;
  localparam int ADDR_W  = 32;
  localparam int WANT_W  = 25;
  localparam int PROD_W  = 28;

  localparam logic [2:0] REG_SMALL_BYTES  = 3'd0;
  localparam logic [2:0] REG_MEDIUM_BYTES = 3'd1;
  localparam logic [2:0] REG_LARGE_BYTES  = 3'd2;
  localparam logic [2:0] REG_HEADER_BYTES = 3'd3;
  localparam logic [2:0] REG_SMALL_END    = 3'd4;
  localparam logic [2:0] REG_MEDIUM_END   = 3'd5;
  localparam logic [2:0] REG_LARGE_END    = 3'd6;

  localparam logic [2:0] ST_ALLOCATED  = 3'd0;
  localparam logic [2:0] ST_FREED      = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd2;
  localparam logic [2:0] ST_EMPTY      = 3'd3;
  localparam logic [2:0] ST_NOT_IN_USE = 3'd4;

  localparam logic [1:0] POOL_SMALL   = 2'd0;
  localparam logic [1:0] POOL_MEDIUM  = 2'd1;
  localparam logic [1:0] POOL_LARGE   = 2'd2;
  localparam logic [1:0] POOL_INVALID = 2'd3;

  localparam logic OP_ALLOC = 1'b0;

  typedef enum logic [1:0] {
    K_ALLOC,
    K_FREE,
    K_TOO_LARGE,
    K_NOT_IN_USE
  } kind_t;

  typedef struct packed {
    logic              operation;
    logic [SIZE_W-1:0] request_size;
    logic [1:0]        free_pool;
    logic [BLK_W-1:0]  free_block;
  } item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [1:0]        pool;
    logic [BLK_W-1:0]  block_number;
    logic [ADDR_W-1:0] block_address;
  } result_t;

  typedef struct packed {
    kind_t            kind;
    logic [1:0]       pool;
    logic [BLK_W-1:0] blk;
  } cmd_t;

  typedef struct packed {
    logic [BYTES_W-1:0] small_bytes;
    logic [BYTES_W-1:0] medium_bytes;
    logic [BYTES_W-1:0] large_bytes;
    logic [HDR_W-1:0]   header;
    logic [ADDR_W-1:0]  small_end;
    logic [ADDR_W-1:0]  medium_end;
    logic [ADDR_W-1:0]  large_end;
  } cfg_t;

endpackage

// ----- hdl/scba_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module scba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/scba_front.sv -----
// Front part: accepts items, picks the size class or rejects, and queues commands.
// Depends on scba_pkg.
`timescale 1ns / 1ps

module scba_front #(
  parameter int SMALL_BLOCKS  = 64,
  parameter int MEDIUM_BLOCKS = 64,
  parameter int LARGE_BLOCKS  = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  scba_pkg::item_t item,
  input  scba_pkg::cfg_t  cfg,
  output logic            cmd_valid,
  output scba_pkg::cmd_t  cmd,
  input  logic            cmd_pop
);

  localparam int QDEPTH = 2;

  scba_pkg::cmd_t q [QDEPTH];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  scba_pkg::cmd_t cls;
  logic [scba_pkg::WANT_W-1:0] want;
  logic [10:0]    limit;
  logic           fb_bad;

  assign busy      = (count == 2'(QDEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_comb begin
    want = scba_pkg::WANT_W'(item.request_size) + scba_pkg::WANT_W'(cfg.header);
    unique case (item.free_pool)
      scba_pkg::POOL_SMALL:  limit = 11'(SMALL_BLOCKS);
      scba_pkg::POOL_MEDIUM: limit = 11'(MEDIUM_BLOCKS);
      default:               limit = 11'(LARGE_BLOCKS);
    endcase
    fb_bad = (item.free_block == 7'd0) || (11'(item.free_block) > limit);

    cls.kind = scba_pkg::K_NOT_IN_USE;
    cls.pool = scba_pkg::POOL_SMALL;
    cls.blk  = item.free_block;
    if (item.operation == scba_pkg::OP_ALLOC) begin
      priority if (want < scba_pkg::WANT_W'(cfg.small_bytes)) begin
        cls.kind = scba_pkg::K_ALLOC;
        cls.pool = scba_pkg::POOL_SMALL;
      end else if (want < scba_pkg::WANT_W'(cfg.medium_bytes)) begin
        cls.kind = scba_pkg::K_ALLOC;
        cls.pool = scba_pkg::POOL_MEDIUM;
      end else if (want < scba_pkg::WANT_W'(cfg.large_bytes)) begin
        cls.kind = scba_pkg::K_ALLOC;
        cls.pool = scba_pkg::POOL_LARGE;
      end else begin
        cls.kind = scba_pkg::K_TOO_LARGE;
      end
    end else if (item.free_pool == scba_pkg::POOL_INVALID) begin
      cls.kind = scba_pkg::K_NOT_IN_USE;
    end else if (fb_bad) begin
      cls.pool = item.free_pool;
    end else begin
      cls.kind = scba_pkg::K_FREE;
      cls.pool = item.free_pool;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

endmodule

// ----- hdl/scba_back.sv -----
// Back part: walks the circular free lists in RAM to allocate and free blocks.
// Depends on scba_pkg and scba_ram.
`timescale 1ns / 1ps

module scba_back #(
  parameter int SMALL_BLOCKS  = 64,
  parameter int MEDIUM_BLOCKS = 64,
  parameter int LARGE_BLOCKS  = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  scba_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  input  scba_pkg::cfg_t    cfg,
  output logic              done,
  output scba_pkg::result_t result
);

  localparam int TOTAL       = SMALL_BLOCKS + MEDIUM_BLOCKS + LARGE_BLOCKS;
  localparam int SLOT_W      = $clog2(TOTAL);
  localparam int BASE_MEDIUM = SMALL_BLOCKS;
  localparam int BASE_LARGE  = SMALL_BLOCKS + MEDIUM_BLOCKS;
  localparam int BW          = scba_pkg::BLK_W;

  typedef enum logic [4:0] {
    S_INIT      = 5'b00001,
    S_IDLE      = 5'b00010,
    S_ALLOC     = 5'b00100,
    S_FREE_CHK  = 5'b01000,
    S_FREE_LINK = 5'b10000
  } state_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [1:0] p, input logic [BW-1:0] n);
    logic [15:0] t;
    unique case (p)
      scba_pkg::POOL_MEDIUM: t = 16'(BASE_MEDIUM);
      scba_pkg::POOL_LARGE:  t = 16'(BASE_LARGE);
      default:               t = 16'd0;
    endcase
    t = t + 16'(n) - 16'd1;
    return t[SLOT_W-1:0];
  endfunction

  function automatic logic [BW-1:0] count_of(input logic [1:0] p);
    logic [BW-1:0] c;
    unique case (p)
      scba_pkg::POOL_MEDIUM: c = BW'(MEDIUM_BLOCKS);
      scba_pkg::POOL_LARGE:  c = BW'(LARGE_BLOCKS);
      default:               c = BW'(SMALL_BLOCKS);
    endcase
    return c;
  endfunction

  state_t state, state_next;

  logic [BW-1:0] head [3];
  logic [2:0]    empty;

  logic [1:0]    p_q;
  logic [BW-1:0] num_q;
  logic [BW-1:0] rd_num_q;
  logic [BW-1:0] hn_q;
  logic          emp_q;
  logic [scba_pkg::PROD_W-1:0] prod_q;

  logic [1:0]        init_p;
  logic [BW-1:0]     init_n;
  logic [BW-1:0]     init_cnt, init_nx, init_pv;
  logic [SLOT_W-1:0] init_slot;
  logic              init_last;

  logic              next_we, prev_we, use_we;
  logic [SLOT_W-1:0] next_waddr, prev_waddr, use_waddr;
  logic [BW-1:0]     next_wdata, prev_wdata;
  logic              use_wdata;
  logic [SLOT_W-1:0] next_raddr, prev_raddr, use_raddr;
  logic [BW-1:0]     next_rdata, prev_rdata;
  logic              use_rdata;

  logic [BW-1:0]      nx, pv;
  logic               inuse;
  logic [SLOT_W-1:0]  d_slot, h_slot;
  logic [BW-1:0]      head_sel, num_sel;
  logic [scba_pkg::BYTES_W-1:0] bytes_sel;
  logic [scba_pkg::ADDR_W-1:0]  end_sel, addr;
  logic               issue, hn_ld;
  logic               head_we, empty_we, empty_wdata;
  logic [BW-1:0]      head_wdata;
  logic               res_we;
  scba_pkg::result_t  res_next;

  scba_ram #(.WIDTH(BW), .DEPTH(TOTAL)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(next_raddr), .rdata(next_rdata)
  );

  scba_ram #(.WIDTH(BW), .DEPTH(TOTAL)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .raddr(prev_raddr), .rdata(prev_rdata)
  );

  scba_ram #(.WIDTH(1), .DEPTH(TOTAL)) u_use_ram (
    .clk(clk), .we(use_we), .waddr(use_waddr), .wdata(use_wdata),
    .raddr(use_raddr), .rdata(use_rdata)
  );

  // After reset every slot is written once with its chained links and a clear use bit.
  assign init_cnt  = count_of(init_p);
  assign init_slot = slot_of(init_p, init_n);
  assign init_nx   = (init_n == init_cnt) ? BW'(1) : init_n + BW'(1);
  assign init_pv   = (init_n == BW'(1)) ? init_cnt : init_n - BW'(1);
  assign init_last = (init_p == scba_pkg::POOL_LARGE) && (init_n == init_cnt);

  assign nx    = next_rdata;
  assign pv    = prev_rdata;
  assign inuse = use_rdata;

  always_comb begin
    unique case (cmd.pool)
      scba_pkg::POOL_MEDIUM: bytes_sel = cfg.medium_bytes;
      scba_pkg::POOL_LARGE:  bytes_sel = cfg.large_bytes;
      default:               bytes_sel = cfg.small_bytes;
    endcase
    unique case (p_q)
      scba_pkg::POOL_MEDIUM: end_sel = cfg.medium_end;
      scba_pkg::POOL_LARGE:  end_sel = cfg.large_end;
      default:               end_sel = cfg.small_end;
    endcase
  end

  assign head_sel = head[cmd.pool];
  assign num_sel  = (cmd.kind == scba_pkg::K_ALLOC) ? head_sel : cmd.blk;
  assign d_slot   = slot_of(cmd.pool, cmd.blk);
  assign h_slot   = slot_of(cmd.pool, head_sel);
  assign addr     = end_sel - scba_pkg::ADDR_W'(prod_q) + scba_pkg::ADDR_W'(cfg.header);

  assign next_raddr = h_slot;
  assign prev_raddr = h_slot;
  assign use_raddr  = d_slot;

  always_comb begin
    state_next  = state;
    cmd_pop     = 1'b0;
    issue       = 1'b0;
    hn_ld       = 1'b0;
    next_we     = 1'b0;
    next_waddr  = slot_of(p_q, num_q);
    next_wdata  = num_q;
    prev_we     = 1'b0;
    prev_waddr  = slot_of(p_q, num_q);
    prev_wdata  = num_q;
    use_we      = 1'b0;
    use_waddr   = slot_of(p_q, num_q);
    use_wdata   = 1'b0;
    head_we     = 1'b0;
    head_wdata  = num_q;
    empty_we    = 1'b0;
    empty_wdata = 1'b0;
    res_we      = 1'b0;
    res_next    = '0;

    unique case (state)
      S_INIT: begin
        next_we    = 1'b1;
        next_waddr = init_slot;
        next_wdata = init_nx;
        prev_we    = 1'b1;
        prev_waddr = init_slot;
        prev_wdata = init_pv;
        use_we     = 1'b1;
        use_waddr  = init_slot;
        use_wdata  = 1'b0;
        if (init_last) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            scba_pkg::K_TOO_LARGE: begin
              res_we          = 1'b1;
              res_next.status = scba_pkg::ST_TOO_LARGE;
            end
            scba_pkg::K_NOT_IN_USE: begin
              res_we          = 1'b1;
              res_next.status = scba_pkg::ST_NOT_IN_USE;
              res_next.pool   = cmd.pool;
            end
            scba_pkg::K_ALLOC: begin
              if (empty[cmd.pool]) begin
                res_we          = 1'b1;
                res_next.status = scba_pkg::ST_EMPTY;
                res_next.pool   = cmd.pool;
              end else begin
                issue      = 1'b1;
                use_we     = 1'b1;
                use_waddr  = h_slot;
                use_wdata  = 1'b1;
                state_next = S_ALLOC;
              end
            end
            default: begin
              issue      = 1'b1;
              state_next = S_FREE_CHK;
            end
          endcase
        end
      end

      S_ALLOC: begin
        res_we                 = 1'b1;
        res_next.status        = scba_pkg::ST_ALLOCATED;
        res_next.pool          = p_q;
        res_next.block_number  = num_q;
        res_next.block_address = addr;
        if (nx == num_q) begin
          empty_we    = 1'b1;
          empty_wdata = 1'b1;
        end else begin
          prev_we    = 1'b1;
          prev_waddr = slot_of(p_q, nx);
          prev_wdata = pv;
          next_we    = 1'b1;
          next_waddr = slot_of(p_q, pv);
          next_wdata = nx;
          head_we    = 1'b1;
          head_wdata = nx;
        end
        state_next = S_IDLE;
      end

      S_FREE_CHK: begin
        if (!inuse) begin
          res_we          = 1'b1;
          res_next.status = scba_pkg::ST_NOT_IN_USE;
          res_next.pool   = p_q;
          state_next      = S_IDLE;
        end else begin
          use_we = 1'b1;
          if (emp_q) begin
            next_we                = 1'b1;
            prev_we                = 1'b1;
            empty_we               = 1'b1;
            head_we                = 1'b1;
            res_we                 = 1'b1;
            res_next.status        = scba_pkg::ST_FREED;
            res_next.pool          = p_q;
            res_next.block_number  = num_q;
            res_next.block_address = addr;
            state_next             = S_IDLE;
          end else begin
            next_we    = 1'b1;
            next_waddr = slot_of(p_q, rd_num_q);
            prev_we    = 1'b1;
            prev_waddr = slot_of(p_q, nx);
            hn_ld      = 1'b1;
            state_next = S_FREE_LINK;
          end
        end
      end

      S_FREE_LINK: begin
        prev_we                = 1'b1;
        prev_wdata             = rd_num_q;
        next_we                = 1'b1;
        next_wdata             = hn_q;
        head_we                = 1'b1;
        res_we                 = 1'b1;
        res_next.status        = scba_pkg::ST_FREED;
        res_next.pool          = p_q;
        res_next.block_number  = num_q;
        res_next.block_address = addr;
        state_next             = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      empty  <= 3'b000;
      done   <= 1'b0;
      init_p <= scba_pkg::POOL_SMALL;
      init_n <= BW'(1);
      for (int i = 0; i < 3; i++) begin
        head[i] <= BW'(1);
      end
    end else begin
      state <= state_next;
      done  <= res_we;
      if (state == S_INIT) begin
        if (init_n == init_cnt) begin
          init_p <= init_p + 2'd1;
          init_n <= BW'(1);
        end else begin
          init_n <= init_n + BW'(1);
        end
      end
      if (head_we) begin
        head[p_q] <= head_wdata;
      end
      if (empty_we) begin
        empty[p_q] <= empty_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_q      <= cmd.pool;
      num_q    <= num_sel;
      rd_num_q <= head_sel;
      emp_q    <= empty[cmd.pool];
      prod_q   <= scba_pkg::PROD_W'(num_sel) * scba_pkg::PROD_W'(bytes_sel);
    end
    if (hn_ld) begin
      hn_q <= nx;
    end
    if (res_we) begin
      result <= res_next;
    end
  end

endmodule

// ----- hdl/size_class_block_allocator.sv -----
// Top level of the size class block allocator: configuration registers,
// front classifier with command queue, and list-walking back part.
// Depends on scba_pkg, scba_front and scba_back.
//
//   Channel   Handshake                    Payload
//   item      start, busy                  item   (scba_pkg::item_t)
//   result    done (one-cycle strobe)      result (scba_pkg::result_t)
//   config    APB psel/penable/pwrite      paddr, pwdata, prdata
//
// A rejected request is answered as it is dequeued, done following in the
// cycle after; an allocate passes through S_ALLOC, and a free through
// S_FREE_CHK and, when the pool's list was not empty, S_FREE_LINK, set by the
// read-modify-write of the free-list links through single-write-port RAMs.
// Synchronous reset restores the register defaults at once; the back part then
// writes the full free lists, one block per cycle, while accepted beats wait in
// the queue.
// busy rises when the two-entry command queue is full; results cannot be held off.
`timescale 1ns / 1ps

module size_class_block_allocator #(
  parameter int SMALL_BLOCKS  = 64,
  parameter int MEDIUM_BLOCKS = 64,
  parameter int LARGE_BLOCKS  = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  scba_pkg::item_t   item,
  output logic              done,
  output scba_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  scba_pkg::cfg_t cfg;
  logic           cmd_valid;
  scba_pkg::cmd_t cmd;
  logic           cmd_pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.small_bytes  <= 21'd64;
      cfg.medium_bytes <= 21'd1024;
      cfg.large_bytes  <= 21'd16384;
      cfg.header       <= 13'd16;
      cfg.small_end    <= 32'd0;
      cfg.medium_end   <= 32'd0;
      cfg.large_end    <= 32'd0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[4:2])
        scba_pkg::REG_SMALL_BYTES:  cfg.small_bytes  <= pwdata[20:0];
        scba_pkg::REG_MEDIUM_BYTES: cfg.medium_bytes <= pwdata[20:0];
        scba_pkg::REG_LARGE_BYTES:  cfg.large_bytes  <= pwdata[20:0];
        scba_pkg::REG_HEADER_BYTES: cfg.header       <= pwdata[12:0];
        scba_pkg::REG_SMALL_END:    cfg.small_end    <= pwdata;
        scba_pkg::REG_MEDIUM_END:   cfg.medium_end   <= pwdata;
        scba_pkg::REG_LARGE_END:    cfg.large_end    <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      scba_pkg::REG_SMALL_BYTES:  prdata = 32'(cfg.small_bytes);
      scba_pkg::REG_MEDIUM_BYTES: prdata = 32'(cfg.medium_bytes);
      scba_pkg::REG_LARGE_BYTES:  prdata = 32'(cfg.large_bytes);
      scba_pkg::REG_HEADER_BYTES: prdata = 32'(cfg.header);
      scba_pkg::REG_SMALL_END:    prdata = cfg.small_end;
      scba_pkg::REG_MEDIUM_END:   prdata = cfg.medium_end;
      scba_pkg::REG_LARGE_END:    prdata = cfg.large_end;
      default:                    prdata = 32'd0;
    endcase
  end

  scba_front #(
    .SMALL_BLOCKS(SMALL_BLOCKS),
    .MEDIUM_BLOCKS(MEDIUM_BLOCKS),
    .LARGE_BLOCKS(LARGE_BLOCKS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .cfg(cfg),
    .cmd_valid(cmd_valid),
    .cmd(cmd),
    .cmd_pop(cmd_pop)
  );

  scba_back #(
    .SMALL_BLOCKS(SMALL_BLOCKS),
    .MEDIUM_BLOCKS(MEDIUM_BLOCKS),
    .LARGE_BLOCKS(LARGE_BLOCKS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd(cmd),
    .cmd_pop(cmd_pop),
    .cfg(cfg),
    .done(done),
    .result(result)
  );

endmodule

// ----- hdl/scba_checker.sv -----
// Port-level checker for the size class block allocator, bound to the top level.
// Depends on scba_pkg and size_class_block_allocator_macros.svh.
`timescale 1ns / 1ps
`include "size_class_block_allocator_macros.svh"

module scba_checker (
  input logic              clk,
  input logic              rst,
  input logic              busy,
  input logic              done,
  input scba_pkg::result_t result
);

  `SCBA_CHECK_NOW(a_reject_has_no_block, done && result.status != scba_pkg::ST_ALLOCATED && result.status != scba_pkg::ST_FREED, result.block_number == 7'd0 && result.block_address == 32'd0, "Rejected beat carries a block.")
  `SCBA_CHECK_NOW(a_too_large_pool_zero, done && result.status == scba_pkg::ST_TOO_LARGE, result.pool == scba_pkg::POOL_SMALL, "Oversized request names a pool.")
  `SCBA_CHECK_NOW(a_grant_names_block, done && (result.status == scba_pkg::ST_ALLOCATED || result.status == scba_pkg::ST_FREED), result.block_number != 7'd0 && result.pool != scba_pkg::POOL_INVALID, "Granted beat lacks a block or pool.")
  `SCBA_CHECK_AFTER(a_quiet_after_reset, rst, !done && !busy, "Block is not idle after reset.")

endmodule

bind size_class_block_allocator scba_checker u_scba_checker (.*);
